// ===== rtl/kvt_pkg.sv =====
// kvt_pkg: shared types and constants of the key-value table
`timescale 1ns / 1ps

package kvt_pkg;

  // fixed port widths
  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned KEY_IN_W  = 32;
  localparam int unsigned VAL_IN_W  = 32;
  localparam int unsigned COUNT_W   = 5;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT   = 3'd0,
    FN_UPDATE   = 3'd1,
    FN_UPSERT   = 3'd2,
    FN_ERASE    = 3'd3,
    FN_CONTAINS = 3'd4
  } kvt_func_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_WALK,
    ST_EMIT
  } kvt_state_e;

  // command broadcast to every cell, acted on only by the hit cell
  typedef struct packed {
    logic upd;
    logic erase;
  } kvt_cmd_t;

endpackage

// ===== rtl/key_value_table.sv =====
// key_value_table: bounded associative key-to-value table built from a row of cells
`timescale 1ns / 1ps
//
// usage
//   input channel: in_valid_i, in_stall_o with func_i, lookup_key_i, new_value_i;
//   an item is taken at a clock edge where valid is high and stall is low
//   output channel: out_valid_o, out_stall_i with success_o, table_full_o,
//   entry_count_o, is_empty_o; exactly one result per item, in order
//   one item is in work at a time; the lookup cycle compares the key in every
//   cell at once; update, erase, contains and refused inserts pass from idle
//   through look and emit, where the result register is loaded, back to idle
//   an insert of an absent key sends a claim token down the cell row, one cell
//   per cycle, until the lowest free cell takes it; unless cell 0 takes it at
//   once, the walk state lies between look and emit until a cell claims it
//   the result register sits apart from the work, so a new item is taken while
//   a result waits; if the receiver still stalls when the next result is ready
//   the block holds it and stalls its input
//   reset clears all valid marks, the count and both channels; keys and values
//   are left as they are and only read behind a set valid mark
//
module key_value_table #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [kvt_pkg::FUNC_W-1:0]   func_i,
  input  logic [kvt_pkg::KEY_IN_W-1:0] lookup_key_i,
  input  logic [kvt_pkg::VAL_IN_W-1:0] new_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         success_o,
  output logic                         table_full_o,
  output logic [kvt_pkg::COUNT_W-1:0]  entry_count_o,
  output logic                         is_empty_o
);

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  kvt_pkg::kvt_state_e state_q, state_d;

  // item registers
  logic [kvt_pkg::FUNC_W-1:0] func_q;
  logic [KEY_BITS-1:0]        key_q, key_in;
  logic [VALUE_BITS-1:0]      value_q, value_in;

  // table occupancy
  logic [CNT_W-1:0] count_q, count_d;

  // pending result
  logic succ_q, succ_d;
  logic full_q, full_d;

  // output register
  logic                        out_valid_q, out_valid_d;
  logic                        out_succ_q, out_full_q, out_empty_q;
  logic [kvt_pkg::COUNT_W-1:0] out_count_q, count_ext;

  // cell row
  logic [ENTRIES-1:0] hit_vec, claim_vec, tok_vec;
  kvt_pkg::kvt_cmd_t  cmd;
  logic               start_tok;
  logic               present, any_claim, is_full;

  // decoded control
  logic in_take, out_take, out_load;
  logic cnt_inc, cnt_dec, set_succ, set_full;
  logic go_insert;

  // low key and value bits of the ports, zero-extended where the table is wider
  if (KEY_BITS <= kvt_pkg::KEY_IN_W) begin : g_key_trunc
    assign key_in = lookup_key_i[KEY_BITS-1:0];
  end else begin : g_key_ext
    assign key_in = {{(KEY_BITS - kvt_pkg::KEY_IN_W){1'b0}}, lookup_key_i};
  end

  if (VALUE_BITS <= kvt_pkg::VAL_IN_W) begin : g_val_trunc
    assign value_in = new_value_i[VALUE_BITS-1:0];
  end else begin : g_val_ext
    assign value_in = {{(VALUE_BITS - kvt_pkg::VAL_IN_W){1'b0}}, new_value_i};
  end

  // count as reported: low bits of the occupancy, zero-extended where the port is wider
  if (CNT_W >= kvt_pkg::COUNT_W) begin : g_cnt_trunc
    assign count_ext = count_q[kvt_pkg::COUNT_W-1:0];
  end else begin : g_cnt_ext
    assign count_ext = {{(kvt_pkg::COUNT_W - CNT_W){1'b0}}, count_q};
  end

  // row of cells; the claim token enters at cell 0 and moves one cell a cycle
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic tok_in;
    if (i == 0) begin : g_first
      assign tok_in = start_tok;
    end else begin : g_next
      assign tok_in = tok_vec[i-1];
    end
    kvt_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .key_i   (key_q),
      .value_i (value_q),
      .token_i (tok_in),
      .token_o (tok_vec[i]),
      .hit_o   (hit_vec[i]),
      .claim_o (claim_vec[i])
    );
  end

  assign present   = |hit_vec;
  assign any_claim = |claim_vec;
  assign is_full   = (count_q == CNT_W'(ENTRIES));

  // handshakes
  assign in_stall_o = (state_q != kvt_pkg::ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;

  // control decode per state
  always_comb begin
    cmd       = '0;
    start_tok = 1'b0;
    cnt_inc   = 1'b0;
    cnt_dec   = 1'b0;
    set_succ  = 1'b0;
    set_full  = 1'b0;
    go_insert = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      kvt_pkg::ST_IDLE: begin
      end
      kvt_pkg::ST_LOOK: begin
        case (func_q)
          kvt_pkg::FN_UPDATE: begin
            cmd.upd  = present;
            set_succ = present;
          end
          kvt_pkg::FN_UPSERT: begin
            cmd.upd   = present;
            set_succ  = present;
            go_insert = !present;
          end
          kvt_pkg::FN_INSERT: begin
            go_insert = !present;
          end
          kvt_pkg::FN_ERASE: begin
            cmd.erase = present;
            cnt_dec   = present;
            set_succ  = present;
          end
          kvt_pkg::FN_CONTAINS: begin
            set_succ = present;
          end
          default: begin
          end
        endcase
        if (go_insert) begin
          if (is_full) begin
            set_full = 1'b1;
          end else begin
            // cell 0 may take the token in this very cycle
            start_tok = 1'b1;
            cnt_inc   = any_claim;
            set_succ  = any_claim;
          end
        end
      end
      kvt_pkg::ST_WALK: begin
        cnt_inc  = any_claim;
        set_succ = any_claim;
      end
      kvt_pkg::ST_EMIT: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kvt_pkg::ST_IDLE: begin
        if (in_take) begin
          state_d = kvt_pkg::ST_LOOK;
        end
      end
      kvt_pkg::ST_LOOK: begin
        if (start_tok && !any_claim) begin
          state_d = kvt_pkg::ST_WALK;
        end else begin
          state_d = kvt_pkg::ST_EMIT;
        end
      end
      kvt_pkg::ST_WALK: begin
        if (any_claim) begin
          state_d = kvt_pkg::ST_EMIT;
        end
      end
      kvt_pkg::ST_EMIT: begin
        if (out_load) begin
          state_d = kvt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kvt_pkg::ST_IDLE;
      end
    endcase
  end

  // count and result flags
  always_comb begin
    count_d = count_q;
    if (cnt_inc) begin
      count_d = count_q + CNT_W'(1);
    end else if (cnt_dec) begin
      count_d = count_q - CNT_W'(1);
    end

    succ_d = succ_q;
    full_d = full_q;
    if (state_q == kvt_pkg::ST_LOOK) begin
      succ_d = set_succ;
      full_d = set_full;
    end else if (set_succ) begin
      succ_d = 1'b1;
    end

    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kvt_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q  <= func_i;
      key_q   <= key_in;
      value_q <= value_in;
    end
    succ_q <= succ_d;
    full_q <= full_d;
    if (out_load) begin
      out_succ_q  <= succ_q;
      out_full_q  <= full_q;
      out_count_q <= count_ext;
      out_empty_q <= (count_q == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign success_o     = out_succ_q;
  assign table_full_o  = out_full_q;
  assign entry_count_o = out_count_q;
  assign is_empty_o    = out_empty_q;

endmodule

// ===== rtl/kvt_cell.sv =====
// kvt_cell: one table entry with key compare and a free-entry claim token
`timescale 1ns / 1ps

module kvt_cell #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kvt_pkg::kvt_cmd_t     cmd_i,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  token_i,
  output logic                  token_o,
  output logic                  hit_o,
  output logic                  claim_o
);

  logic                  valid_q, valid_d;
  logic                  token_q, token_d;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;

  assign hit_o   = valid_q && (key_q == key_i);
  // a free cell keeps the token, an occupied one hands it on
  assign claim_o = token_i && !valid_q;
  assign token_o = token_q;

  always_comb begin
    valid_d = valid_q;
    if (claim_o) begin
      valid_d = 1'b1;
    end else if (cmd_i.erase && hit_o) begin
      valid_d = 1'b0;
    end
    token_d = token_i && valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      token_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      token_q <= token_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (claim_o) begin
      key_q   <= key_i;
      value_q <= value_i;
    end else if (cmd_i.upd && hit_o) begin
      value_q <= value_i;
    end
  end

endmodule

// ===== dv/tb_key_value_table.sv =====
// tb_key_value_table: self-checking testbench of the key-value table against a shadow table
`timescale 1ns / 1ps

module tb_key_value_table;

  localparam int TABLE_DEPTH  = 16;
  localparam int FUNC_MAX     = (1 << kvt_pkg::FUNC_W) - 1;
  localparam int POOL_SIZE    = 24;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [kvt_pkg::FUNC_W-1:0]   func;
    logic [kvt_pkg::KEY_IN_W-1:0] key;
    logic [kvt_pkg::VAL_IN_W-1:0] value;
  } kvt_op_t;

  typedef struct packed {
    logic                        success;
    logic                        full;
    logic [kvt_pkg::COUNT_W-1:0] count;
    logic                        empty;
  } kvt_res_t;

  // dut ports; the inputs that the bench drives are known from time zero
  logic                         clk_i        = 1'b0;
  logic                         rst_n        = 1'b0;
  logic                         in_valid     = 1'b0;
  logic                         in_stall;
  logic [kvt_pkg::FUNC_W-1:0]   cur_func     = '0;
  logic [kvt_pkg::KEY_IN_W-1:0] cur_key      = '0;
  logic [kvt_pkg::VAL_IN_W-1:0] cur_value    = '0;
  logic                         out_valid;
  logic                         out_stall    = 1'b0;
  logic                         res_success;
  logic                         res_full;
  logic [kvt_pkg::COUNT_W-1:0]  res_count;
  logic                         res_empty;

  // shadow copy of the table
  logic [kvt_pkg::KEY_IN_W-1:0] shadow_keys   [TABLE_DEPTH];
  logic [kvt_pkg::VAL_IN_W-1:0] shadow_values [TABLE_DEPTH];
  logic                         shadow_valid  [TABLE_DEPTH];
  int                           shadow_count;

  kvt_op_t  pending_ops[$];
  kvt_res_t predicted_results[$];
  logic [kvt_pkg::KEY_IN_W-1:0] key_pool [POOL_SIZE];

  int items_queued   = 0;
  int items_accepted = 0;
  int results_seen   = 0;
  int error_count    = 0;
  int full_refusals  = 0;
  int empty_results  = 0;
  int peak_count     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int cycle_count    = 0;

  key_value_table #(
    .ENTRIES   (TABLE_DEPTH),
    .KEY_BITS  (kvt_pkg::KEY_IN_W),
    .VALUE_BITS(kvt_pkg::VAL_IN_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .func_i       (cur_func),
    .lookup_key_i (cur_key),
    .new_value_i  (cur_value),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .success_o    (res_success),
    .table_full_o (res_full),
    .entry_count_o(res_count),
    .is_empty_o   (res_empty)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count++;

  // apply one item to the shadow table and return the result it should give
  function automatic kvt_res_t apply_to_shadow_table(
    input logic [kvt_pkg::FUNC_W-1:0]   func,
    input logic [kvt_pkg::KEY_IN_W-1:0] key,
    input logic [kvt_pkg::VAL_IN_W-1:0] value
  );
    kvt_res_t r;
    int hit;
    int slot;
    hit  = -1;
    slot = -1;
    r    = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (hit < 0 && shadow_valid[i] && shadow_keys[i] == key) hit = i;
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (slot < 0 && !shadow_valid[i]) slot = i;
    end
    case (func)
      kvt_pkg::FN_UPDATE, kvt_pkg::FN_UPSERT: begin
        if (hit >= 0) begin
          shadow_values[hit] = value;
          r.success = 1'b1;
        end
      end
      kvt_pkg::FN_ERASE: begin
        if (hit >= 0) begin
          shadow_valid[hit] = 1'b0;
          shadow_count--;
          r.success = 1'b1;
        end
      end
      kvt_pkg::FN_CONTAINS: r.success = (hit >= 0);
      default: ;
    endcase
    // insert, or insert-or-update of an absent key, takes the lowest free entry
    if ((func == kvt_pkg::FN_INSERT || func == kvt_pkg::FN_UPSERT) && hit < 0) begin
      if (slot >= 0) begin
        shadow_keys[slot]   = key;
        shadow_values[slot] = value;
        shadow_valid[slot]  = 1'b1;
        shadow_count++;
        r.success = 1'b1;
      end else begin
        r.full = 1'b1;
      end
    end
    r.count = shadow_count[kvt_pkg::COUNT_W-1:0];
    r.empty = (shadow_count == 0);
    return r;
  endfunction

  task automatic queue_op(input logic [kvt_pkg::FUNC_W-1:0]   func,
                          input logic [kvt_pkg::KEY_IN_W-1:0] key,
                          input logic [kvt_pkg::VAL_IN_W-1:0] value);
    kvt_op_t op;
    op.func  = func;
    op.key   = key;
    op.value = value;
    pending_ops.push_back(op);
    items_queued++;
  endtask

  // block until every queued item has been taken and answered
  task automatic wait_drained();
    while (items_accepted != items_queued || predicted_results.size() != 0) @(posedge clk_i);
  endtask

  // random traffic: fill and drain runs over a key pool, mixed ops, and some noise
  task automatic gen_traffic(input int n_items);
    int made;
    int kind;
    int base;
    logic [kvt_pkg::FUNC_W-1:0] f;
    made = 0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    while (made < n_items) begin
      kind = $urandom_range(99);
      base = $urandom_range(POOL_SIZE - 1);
      if (kind < 25) begin
        // distinct pool keys, more than the table holds, so inserts overflow
        for (int i = 0; i < 20; i++) begin
          f = $urandom_range(1) ? kvt_pkg::FN_INSERT : kvt_pkg::FN_UPSERT;
          queue_op(f, key_pool[(base + i) % POOL_SIZE], $urandom);
        end
        made += 20;
      end else if (kind < 45) begin
        for (int i = 0; i < POOL_SIZE; i++) begin
          f = ($urandom_range(3) == 0) ? kvt_pkg::FN_CONTAINS : kvt_pkg::FN_ERASE;
          queue_op(f, key_pool[(base + i) % POOL_SIZE], $urandom);
        end
        made += POOL_SIZE;
      end else if (kind < 90) begin
        for (int i = 0; i < 10; i++) begin
          f = kvt_pkg::FUNC_W'($urandom_range(kvt_pkg::FN_INSERT, kvt_pkg::FN_CONTAINS));
          queue_op(f, key_pool[$urandom_range(POOL_SIZE - 1)], $urandom);
        end
        made += 10;
      end else begin
        for (int i = 0; i < 5; i++) begin
          f = kvt_pkg::FUNC_W'($urandom_range(kvt_pkg::FN_INSERT, FUNC_MAX));
          queue_op(f, $urandom, $urandom);
        end
        made += 5;
      end
    end
  endtask

  // input driver: holds an item until taken, idles at random between items
  always @(posedge clk_i) begin : drive_items
    kvt_op_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_results.push_back(apply_to_shadow_table(cur_func, cur_key, cur_value));
        items_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_ops.pop_front();
          in_valid  <= 1'b1;
          cur_func  <= nxt.func;
          cur_key   <= nxt.key;
          cur_value <= nxt.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side stall: random, or a long hold-off when one is requested
  always @(posedge clk_i) begin : drive_stall
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result monitor: compare each taken result with the oldest prediction
  always @(posedge clk_i) begin : check_results
    kvt_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (predicted_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: success %0b full %0b count %0d empty %0b",
                   res_success, res_full, res_count, res_empty);
      end else begin
        want = predicted_results.pop_front();
        if (res_success !== want.success || res_full !== want.full ||
            res_count !== want.count || res_empty !== want.empty) begin
          error_count++;
          if (error_count <= 10)
            $display({"mismatch on result %0d: expected s%0b f%0b c%0d e%0b,",
                      " got s%0b f%0b c%0d e%0b"},
                     results_seen, want.success, want.full, want.count, want.empty,
                     res_success, res_full, res_count, res_empty);
        end
        if (want.full) full_refusals++;
        if (want.empty) empty_results++;
        if (want.count > peak_count) peak_count = want.count;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             predicted_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : run_test
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      shadow_keys[i]   = '0;
      shadow_values[i] = '0;
      shadow_valid[i]  = 1'b0;
    end
    shadow_count = 0;
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;

    // directed: empty-table misses, extreme keys and values, every op, unknown codes
    queue_op(kvt_pkg::FN_CONTAINS, '0, '0);
    queue_op(kvt_pkg::FN_ERASE, 32'h1234_5678, '0);
    queue_op(kvt_pkg::FN_UPDATE, 32'h1234_5678, '1);
    queue_op(kvt_pkg::FN_INSERT, '0, '1);
    queue_op(kvt_pkg::FN_INSERT, '1, '0);
    queue_op(kvt_pkg::FN_INSERT, '0, 32'h5555_5555);    // key already present
    queue_op(kvt_pkg::FN_UPDATE, '0, 32'hAAAA_AAAA);
    queue_op(kvt_pkg::FN_UPSERT, '1, 32'h0F0F_0F0F);     // present key
    queue_op(kvt_pkg::FN_UPSERT, 32'hA5A5_A5A5, '1);     // absent key
    queue_op(kvt_pkg::FN_CONTAINS, '1, '0);
    queue_op(kvt_pkg::FN_CONTAINS, 32'h5A5A_5A5A, '0);
    queue_op(kvt_pkg::FN_ERASE, '0, '0);
    queue_op(kvt_pkg::FN_ERASE, '0, '0);                 // now absent
    queue_op(kvt_pkg::FN_INSERT, 32'h0000_0001, 32'h8000_0000);
    for (int f = kvt_pkg::FN_CONTAINS + 1; f <= FUNC_MAX; f++) begin
      queue_op(kvt_pkg::FUNC_W'(f), '1, '1);
    end
    queue_op(kvt_pkg::FN_ERASE, '1, '0);
    queue_op(kvt_pkg::FN_ERASE, 32'hA5A5_A5A5, '0);
    queue_op(kvt_pkg::FN_ERASE, 32'h0000_0001, '0);
    queue_op(kvt_pkg::FN_CONTAINS, '0, '0);
    wait_drained();

    // random phases with different idle patterns
    send_idle_pct = 0;  recv_stall_pct = 0;  gen_traffic(290); wait_drained();
    send_idle_pct = 62; recv_stall_pct = 0;  gen_traffic(290); wait_drained();
    send_idle_pct = 0;  recv_stall_pct = 62; gen_traffic(290); wait_drained();
    send_idle_pct = 19; recv_stall_pct = 19; gen_traffic(290); wait_drained();

    // long receiver hold-off while items keep coming, so the input backs up
    send_idle_pct = 0;  recv_stall_pct = 0;
    hold_requests++;
    gen_traffic(50);
    wait_drained();
    // sender pause: nothing offered until every result is back, then resume
    gen_traffic(30);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (predicted_results.size() != 0) error_count += predicted_results.size();
    $display("sent %0d items, checked %0d results, %0d errors", items_accepted,
             results_seen, error_count);
    $display("table-full refusals %0d, empty-table results %0d, peak occupancy %0d",
             full_refusals, empty_results, peak_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/kvt_pkg.sv
rtl/kvt_cell.sv
rtl/key_value_table.sv
dv/tb_key_value_table.sv
